/* rtl/edid_cec_physical_address_parser_core_assert.svh */
// Assertion macros used by the checker file of this block.
`ifndef EDID_CEC_PHYSICAL_ADDRESS_PARSER_CORE_ASSERT_SVH
`define EDID_CEC_PHYSICAL_ADDRESS_PARSER_CORE_ASSERT_SVH

// An implication checked on every clock edge outside reset.
`define ECPA_ASSERT_IMPLY(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed: label");

// An implication whose consequent is checked in the cycle after the antecedent.
`define ECPA_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed: label");

`endif

/* rtl/ecpa_pkg.sv */
package ecpa_pkg;

   localparam logic [8:0] EXTENSION_OFFSET = 9'd128;
   localparam logic [8:0] OFFSET_MAX       = 9'd511;
   localparam logic [8:0] HEADER_LAST      = 9'd6;

   localparam logic [7:0] HEADER_FIRST_BYTE = 8'h00;
   localparam logic [7:0] HEADER_FILL_BYTE  = 8'hFF;
   localparam logic [7:0] CEA_EXT_TAG       = 8'h02;
   localparam logic [7:0] MIN_COLLECTION    = 8'd4;
   localparam logic [2:0] VENDOR_TAG        = 3'b011;
   localparam logic [4:0] MIN_VENDOR_LEN    = 5'd5;
   localparam logic [7:0] OUI_BYTE0         = 8'h03;
   localparam logic [7:0] OUI_BYTE1         = 8'h0C;
   localparam logic [7:0] OUI_BYTE2         = 8'h00;
   localparam logic [15:0] NOT_FOUND_ADDR   = 16'hFFFF;

   localparam logic [4:0] POS_OUI0    = 5'd0;
   localparam logic [4:0] POS_OUI1    = 5'd1;
   localparam logic [4:0] POS_OUI2    = 5'd2;
   localparam logic [4:0] POS_ADDR_HI = 5'd3;
   localparam logic [4:0] POS_ADDR_LO = 5'd4;

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_EXT,
      PH_BLOCK_HDR,
      PH_BLOCK_BODY,
      PH_DONE
   } phase_type;

   typedef struct packed {
      logic [8:0] byte_offset;
      phase_type  parse_phase;
      logic [8:0] collection_end;
      logic [4:0] block_bytes_left;
      logic [4:0] block_position;
      logic       block_is_vendor;
      logic       oui_matches;
      logic [7:0] address_high_byte;
   } parse_state_type;

   localparam parse_state_type PARSE_STATE_RESET = '{
      byte_offset:       9'd0,
      parse_phase:       PH_HEADER,
      collection_end:    9'd0,
      block_bytes_left:  5'd0,
      block_position:    5'd0,
      block_is_vendor:   1'b0,
      oui_matches:       1'b0,
      address_high_byte: 8'd0
   };

   typedef struct packed {
      logic        emit;
      logic        found;
      logic [15:0] physical_address;
   } parse_result_type;

endpackage

/* rtl/ecpa_parse_step.sv */
module ecpa_parse_step (
   input  ecpa_pkg::parse_state_type  cur_state,
   input  logic [7:0]                 edid_byte,
   input  logic                       image_start,
   input  logic                       image_end,
   output ecpa_pkg::parse_state_type  next_state,
   output ecpa_pkg::parse_result_type result
);

   ecpa_pkg::parse_state_type s;
   logic [8:0] off;
   logic [2:0] tag;
   logic [4:0] len;
   logic       run_out;
   logic [4:0] left_dec;

   always_comb begin
      s   = image_start ? ecpa_pkg::PARSE_STATE_RESET : cur_state;
      off = s.byte_offset;
      tag = edid_byte[7:5];
      len = edid_byte[4:0];
      // The next block header would sit at or past the collection end.
      run_out  = ({1'b0, off} + 10'd1) >= {1'b0, s.collection_end};
      left_dec = s.block_bytes_left - 5'd1;
      next_state = s;
      result.emit = 1'b0;
      result.found = 1'b0;
      result.physical_address = ecpa_pkg::NOT_FOUND_ADDR;

      if (s.parse_phase != ecpa_pkg::PH_DONE) begin
         case (s.parse_phase)
            ecpa_pkg::PH_HEADER: begin
               if (edid_byte != ((off == 9'd0) ? ecpa_pkg::HEADER_FIRST_BYTE
                                               : ecpa_pkg::HEADER_FILL_BYTE)) begin
                  result.emit = 1'b1;
               end else if (off >= ecpa_pkg::HEADER_LAST) begin
                  next_state.parse_phase = ecpa_pkg::PH_EXT;
               end
            end
            ecpa_pkg::PH_EXT: begin
               if (off == ecpa_pkg::EXTENSION_OFFSET) begin
                  if (edid_byte != ecpa_pkg::CEA_EXT_TAG) begin
                     result.emit = 1'b1;
                  end
               end else if (off == ecpa_pkg::EXTENSION_OFFSET + 9'd2) begin
                  if (edid_byte <= ecpa_pkg::MIN_COLLECTION) begin
                     result.emit = 1'b1;
                  end else begin
                     next_state.collection_end =
                        ecpa_pkg::EXTENSION_OFFSET + {1'b0, edid_byte};
                  end
               end else if (off == ecpa_pkg::EXTENSION_OFFSET + 9'd3) begin
                  next_state.parse_phase = ecpa_pkg::PH_BLOCK_HDR;
               end
            end
            ecpa_pkg::PH_BLOCK_HDR: begin
               next_state.block_is_vendor = (tag == ecpa_pkg::VENDOR_TAG) &&
                                            (len >= ecpa_pkg::MIN_VENDOR_LEN);
               next_state.block_position   = 5'd0;
               next_state.block_bytes_left = len;
               next_state.oui_matches      = 1'b1;
               if (len == 5'd0) begin
                  if (run_out) begin
                     result.emit = 1'b1;
                  end
               end else begin
                  next_state.parse_phase = ecpa_pkg::PH_BLOCK_BODY;
               end
            end
            ecpa_pkg::PH_BLOCK_BODY: begin
               if (s.block_is_vendor && (s.block_position == ecpa_pkg::POS_ADDR_LO)
                   && s.oui_matches) begin
                  result.emit  = 1'b1;
                  result.found = 1'b1;
                  result.physical_address = {s.address_high_byte, edid_byte};
               end else begin
                  if (s.block_is_vendor) begin
                     case (s.block_position)
                        ecpa_pkg::POS_OUI0:
                           next_state.oui_matches = (edid_byte == ecpa_pkg::OUI_BYTE0);
                        ecpa_pkg::POS_OUI1:
                           next_state.oui_matches = s.oui_matches &&
                                                    (edid_byte == ecpa_pkg::OUI_BYTE1);
                        ecpa_pkg::POS_OUI2:
                           next_state.oui_matches = s.oui_matches &&
                                                    (edid_byte == ecpa_pkg::OUI_BYTE2);
                        ecpa_pkg::POS_ADDR_HI:
                           next_state.address_high_byte = edid_byte;
                        default: ;
                     endcase
                  end
                  next_state.block_position   = s.block_position + 5'd1;
                  next_state.block_bytes_left = left_dec;
                  if (left_dec == 5'd0) begin
                     if (run_out) begin
                        result.emit = 1'b1;
                     end else begin
                        next_state.parse_phase = ecpa_pkg::PH_BLOCK_HDR;
                     end
                  end
               end
            end
            default: ;
         endcase

         if (off < ecpa_pkg::OFFSET_MAX) begin
            next_state.byte_offset = off + 9'd1;
         end
         // A byte marked as the last one settles an open parse as not found.
         if (!result.emit && image_end) begin
            result.emit = 1'b1;
         end
         if (result.emit) begin
            next_state.parse_phase = ecpa_pkg::PH_DONE;
         end
      end
   end

endmodule

/* rtl/edid_cec_physical_address_parser_core.sv */
// Channel  Direction  Ports                                        Transfer
// req      in         req_edid_byte, req_image_start, req_image_end req_valid & req_ready
// rsp      out        rsp_found, rsp_physical_address              rsp_valid & rsp_ready
//
// One EDID byte per cycle while rsp is not stalled: a byte lands in the input register, and the next cycle
// updates the parse state and, at the deciding byte, loads the result register.
// A req transfer reaches the result through the input register and then the result register.
// Synchronous reset clears both valid flags and the parse state.
// A result waiting on rsp_ready holds one byte in the input register; req_ready
// falls only when both registers are occupied and rsp is stalled.
module edid_cec_physical_address_parser_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_edid_byte,
   input  logic        req_image_start,
   input  logic        req_image_end,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_found,
   output logic [15:0] rsp_physical_address
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_start_ff, in_end_ff;

   ecpa_pkg::parse_state_type  state_ff, state_in, step_state;
   ecpa_pkg::parse_result_type step_result;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        found_ff, found_in;
   logic [15:0] addr_ff, addr_in;

   logic out_free, advance, req_xfer;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;
   assign req_xfer  = req_valid && req_ready;

   ecpa_parse_step u_step (
      .cur_state   (state_ff),
      .edid_byte   (in_byte_ff),
      .image_start (in_start_ff),
      .image_end   (in_end_ff),
      .next_state  (step_state),
      .result      (step_result)
   );

   always_comb begin
      in_valid_in  = req_xfer || (in_valid_ff && !advance);
      state_in     = advance ? step_state : state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      found_in     = found_ff;
      addr_in      = addr_ff;
      if (advance) begin
         rsp_valid_in = step_result.emit;
         found_in     = step_result.found;
         addr_in      = step_result.physical_address;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= ecpa_pkg::PARSE_STATE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_byte_ff  <= req_edid_byte;
         in_start_ff <= req_image_start;
         in_end_ff   <= req_image_end;
      end
      found_ff <= found_in;
      addr_ff  <= addr_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_found            = found_ff;
   assign rsp_physical_address = addr_ff;

endmodule

/* rtl/ecpa_checker.sv */
`include "edid_cec_physical_address_parser_core_assert.svh"

module ecpa_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [7:0]  req_edid_byte,
   input logic        req_image_start,
   input logic        req_image_end,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_found,
   input logic [15:0] rsp_physical_address
);

   logic rsp_stall;
   logic req_seen;

   assign rsp_stall = rsp_valid && !rsp_ready;
   assign req_seen  = req_valid && req_ready && (req_image_start || req_image_end ||
                                                 (req_edid_byte != 8'd0));

   // A not-found result always carries the all-ones address.
   `ECPA_ASSERT_IMPLY(a_not_found_addr, clock, reset, rsp_valid && !rsp_found,
                      rsp_physical_address == ecpa_pkg::NOT_FOUND_ADDR)
   // The cycle after reset shows no result.
   `ECPA_ASSERT_IMPLY(a_reset_clears, clock, 1'b0, $past(reset), !rsp_valid)
   // A stalled result stays up.
   `ECPA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid)
   // The input side keeps taking bytes while the result side drains.
   `ECPA_ASSERT_IMPLY(a_req_ready_free, clock, reset, !rsp_valid || rsp_ready,
                      req_ready || req_seen)

endmodule

bind edid_cec_physical_address_parser_core ecpa_checker u_ecpa_checker (.*);
